// ----- sv/qfwd_pkg.sv -----
// ---------------------------------------------------------------------------
// qfwd_pkg : shared types and constants of the Q factor wake detector
// Payload structs, configuration struct, register indexes and phase codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qfwd_pkg;

  // defaults of the top-level parameters
  localparam int WarmupSamplesDefault = 20;
  localparam int FLowLimitDefault     = 0;

  // field widths
  localparam int PhaseW  = 3;
  localparam int SampleW = 16;
  localparam int RefW    = 17;
  localparam int MarginW = 16;
  localparam int WarmW   = 5;
  localparam int RecovW  = 3;
  localparam int TimeW   = 10;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 17;

  // completed-charge timeout: count * step must exceed the limit
  localparam int TimeoutStep  = 750;
  localparam int TimeoutLimit = 11 * 60 * 1000;
  localparam logic [TimeW-1:0] TIMEOUT_COUNT_MAX = TimeW'(TimeoutLimit / TimeoutStep);
  localparam logic [TimeW-1:0] TIMEOUT_SAT       = {TimeW{1'b1}};

  // fault phases need one more than this many recoveries in a row
  localparam logic [RecovW-1:0] RECOVERIES_NEEDED = 3'd3;

  // idle phase codes
  localparam logic [PhaseW-1:0] PH_STANDBY    = 3'd0;
  localparam logic [PhaseW-1:0] PH_COMPLETE   = 3'd1;
  localparam logic [PhaseW-1:0] PH_FAULT_LAST = 3'd5;

  // request types
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_Q_REFERENCE      = 4'd0;
  localparam logic [CfgAddrW-1:0] REG_Q_OBJECT_MARGIN  = 4'd1;
  localparam logic [CfgAddrW-1:0] REG_Q_RECOVER_MARGIN = 4'd2;
  localparam logic [CfgAddrW-1:0] REG_Q_HIGH_LIMIT     = 4'd3;
  localparam logic [CfgAddrW-1:0] REG_F_REFERENCE      = 4'd4;
  localparam logic [CfgAddrW-1:0] REG_F_OBJECT_MARGIN  = 4'd5;
  localparam logic [CfgAddrW-1:0] REG_F_RECOVER_MARGIN = 4'd6;
  localparam logic [CfgAddrW-1:0] REG_F_HIGH_LIMIT     = 4'd7;

  typedef struct packed {
    logic               req_type;
    logic [PhaseW-1:0]  phase_in;
    logic [SampleW-1:0] q_sample;
    logic [SampleW-1:0] f_sample;
  } in_item_t;

  typedef struct packed {
    logic              wake;
    logic [PhaseW-1:0] phase_out;
    logic              settling;
  } out_item_t;

  typedef struct packed {
    logic [RefW-1:0]    q_reference;
    logic [MarginW-1:0] q_object_margin;
    logic [MarginW-1:0] q_recover_margin;
    logic [MarginW-1:0] q_high_limit;
    logic [RefW-1:0]    f_reference;
    logic [MarginW-1:0] f_object_margin;
    logic [MarginW-1:0] f_recover_margin;
    logic [RefW-1:0]    f_high_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/qfwd_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// qfwd_cfg_regs : configuration register file
// Eight threshold registers written through a plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qfwd_cfg_regs
  import qfwd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output cfg_t                     cfg
);

  cfg_t regs;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.q_reference      <= '0;
      regs.q_object_margin  <= MarginW'(20);
      regs.q_recover_margin <= '0;
      regs.q_high_limit     <= '1;
      regs.f_reference      <= '0;
      regs.f_object_margin  <= '0;
      regs.f_recover_margin <= '0;
      regs.f_high_limit     <= '1;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_Q_REFERENCE:      regs.q_reference      <= cfg_data;
        REG_Q_OBJECT_MARGIN:  regs.q_object_margin  <= cfg_data[MarginW-1:0];
        REG_Q_RECOVER_MARGIN: regs.q_recover_margin <= cfg_data[MarginW-1:0];
        REG_Q_HIGH_LIMIT:     regs.q_high_limit     <= cfg_data[MarginW-1:0];
        REG_F_REFERENCE:      regs.f_reference      <= cfg_data;
        REG_F_OBJECT_MARGIN:  regs.f_object_margin  <= cfg_data[MarginW-1:0];
        REG_F_RECOVER_MARGIN: regs.f_recover_margin <= cfg_data[MarginW-1:0];
        REG_F_HIGH_LIMIT:     regs.f_high_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ----- sv/qfwd_core.sv -----
// ---------------------------------------------------------------------------
// qfwd_core : idle phase state and wake decision
// Holds phase and counters, evaluates one transaction per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qfwd_core
  import qfwd_pkg::*;
#(
  parameter int WARMUP_SAMPLES = WarmupSamplesDefault,
  parameter int F_LOW_LIMIT    = FLowLimitDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step_en,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  localparam logic [WarmW-1:0]   WARMUP_LIM = WarmW'(WARMUP_SAMPLES);
  localparam logic [SampleW-1:0] F_LOW_LIM  = SampleW'(F_LOW_LIMIT);

  logic [PhaseW-1:0] idle_phase, idle_phase_next;
  logic [WarmW-1:0]  warmup_count, warmup_count_next;
  logic [RecovW-1:0] recovery_count, recovery_count_next;
  logic [TimeW-1:0]  timeout_count, timeout_count_next;

  logic [RefW-1:0] q_rec_sum, f_rec_sum, q_obj_sum, f_obj_sum;
  logic            recovered, object_seen, wake;
  logic [RecovW-1:0] recov_inc;
  logic [TimeW-1:0]  time_inc;

  // threshold sums and compares
  always_comb begin
    q_rec_sum = {1'b0, item.q_sample} + {1'b0, cfg.q_recover_margin};
    f_rec_sum = {1'b0, item.f_sample} + {1'b0, cfg.f_recover_margin};
    q_obj_sum = {1'b0, item.q_sample} + {1'b0, cfg.q_object_margin};
    f_obj_sum = {1'b0, item.f_sample} + {1'b0, cfg.f_object_margin};
    recovered = (q_rec_sum > cfg.q_reference) && (item.q_sample < cfg.q_high_limit) &&
                (f_rec_sum > cfg.f_reference) &&
                ({1'b0, item.f_sample} < cfg.f_high_limit);
    object_seen = (q_obj_sum < cfg.q_reference) ||
                  ((item.f_sample > F_LOW_LIM) && (f_obj_sum < cfg.f_reference));
  end

  // next state per phase
  always_comb begin
    idle_phase_next     = idle_phase;
    warmup_count_next   = warmup_count;
    recovery_count_next = recovery_count;
    timeout_count_next  = timeout_count;
    wake                = 1'b0;
    recov_inc           = recovery_count + 3'd1;
    time_inc            = (timeout_count < TIMEOUT_SAT) ? timeout_count + 10'd1
                                                        : timeout_count;
    if (item.req_type == REQ_LOAD) begin
      idle_phase_next     = item.phase_in;
      warmup_count_next   = '0;
      recovery_count_next = '0;
      timeout_count_next  = '0;
    end else if (warmup_count < WARMUP_LIM) begin
      warmup_count_next = warmup_count + 5'd1;
    end else if (idle_phase == PH_STANDBY) begin
      wake = object_seen;
    end else if (idle_phase == PH_COMPLETE) begin
      if (recovered) begin
        idle_phase_next    = PH_STANDBY;
        timeout_count_next = '0;
      end else begin
        timeout_count_next = time_inc;
        if (time_inc > TIMEOUT_COUNT_MAX) begin
          idle_phase_next = PH_STANDBY;
        end
      end
    end else if (idle_phase <= PH_FAULT_LAST) begin
      if (recovered) begin
        recovery_count_next = recov_inc;
        if (recov_inc > RECOVERIES_NEEDED) begin
          recovery_count_next = '0;
          idle_phase_next     = PH_STANDBY;
        end
      end else begin
        recovery_count_next = '0;
      end
    end else begin
      idle_phase_next = PH_STANDBY;
    end
  end

  // result of this step
  always_comb begin
    result.wake      = wake;
    result.phase_out = idle_phase_next;
    result.settling  = (warmup_count_next < WARMUP_LIM);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_phase     <= PH_STANDBY;
      warmup_count   <= '0;
      recovery_count <= '0;
      timeout_count  <= '0;
    end else if (step_en) begin
      idle_phase     <= idle_phase_next;
      warmup_count   <= warmup_count_next;
      recovery_count <= recovery_count_next;
      timeout_count  <= timeout_count_next;
    end
  end

  // warm-up counter stops at its limit
  a_warmup_bound: assert property (@(posedge clk) disable iff (rst)
    warmup_count <= WARMUP_LIM)
    else $error("warm-up count past its limit");

  // a fourth recovery in a row always clears the count
  a_recovery_bound: assert property (@(posedge clk) disable iff (rst)
    recovery_count <= RECOVERIES_NEEDED + 3'd1)
    else $error("recovery count past four");

  // timeout only runs in the completed-charge phase or after leaving it
  a_timeout_phase: assert property (@(posedge clk) disable iff (rst)
    timeout_count != '0 |-> (idle_phase == PH_STANDBY || idle_phase == PH_COMPLETE))
    else $error("timeout count set in a foreign phase");

  // fault phases hold no recovery progress once left
  a_recovery_phase: assert property (@(posedge clk) disable iff (rst)
    recovery_count != '0 |-> (idle_phase != PH_STANDBY && idle_phase != PH_COMPLETE))
    else $error("recovery count set outside the fault phases");

endmodule

`default_nettype wire

// ----- sv/q_factor_wake_detector_top.sv -----
// ---------------------------------------------------------------------------
// q_factor_wake_detector_top : sleep-mode wake qualifier
// Input register, decision core and result register with valid/stall.
// ---------------------------------------------------------------------------
//  channel | signals                          | moves
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_stall, in_data      | load or sample transaction
//  out     | out_valid, out_stall, out_data   | one result per transaction
//  cfg     | cfg_write, cfg_addr, cfg_data    | threshold register write
//
//  one transaction per cycle sustained while out_stall is low; a result passes
//  the input register, then the core's single compare round into the result
//  register
//  rst is synchronous: phase standby, counters zero, registers to defaults
//  out_stall holds the result register and, once the input register is
//  full too, raises in_stall in the same cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q_factor_wake_detector_top
  import qfwd_pkg::*;
#(
  parameter int WARMUP_SAMPLES = WarmupSamplesDefault,
  parameter int F_LOW_LIMIT    = FLowLimitDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                cfg_write,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  pipe_item;
  logic      pipe_valid, pipe_valid_next;
  logic      out_valid_next;
  logic      advance, accept;
  out_item_t result;

  // handshake control
  always_comb begin
    advance         = pipe_valid && (!out_valid || !out_stall);
    in_stall        = pipe_valid && !advance;
    accept          = in_valid && !in_stall;
    pipe_valid_next = accept ? 1'b1 : (advance ? 1'b0 : pipe_valid);
    out_valid_next  = advance ? 1'b1 : (out_stall ? out_valid : 1'b0);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= pipe_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pipe_item <= in_data;
    end
  end

  qfwd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qfwd_core #(
    .WARMUP_SAMPLES (WARMUP_SAMPLES),
    .F_LOW_LIMIT    (F_LOW_LIMIT)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (pipe_item),
    .cfg     (cfg),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // a wake result only ever comes from standby after warm-up
  a_wake_standby: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.wake |-> out_data.phase_out == PH_STANDBY && !out_data.settling)
    else $error("wake outside settled standby");

  // input side only stalls when the input register is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> pipe_valid && out_valid && out_stall)
    else $error("input stalled without a held result");

  // a held result is not overwritten by the core
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
